// File: design/prtp_pkg.sv
// Shared types and constants for the resource-data tag parser.
// No dependencies; every module of the block and the testbench import this package.
package prtp_pkg;

    localparam int MAX_ID_CHARS = 127;
    localparam int ID_COUNT_W = 7;
    localparam int BYTES_LEFT_W = 16;

    localparam logic [ID_COUNT_W-1:0] ID_LIMIT = ID_COUNT_W'(MAX_ID_CHARS);
    localparam logic [3:0] TAG_END = 4'hF;
    localparam logic [6:0] TAG_ID_ANSI = 7'h02;

    typedef enum logic [4:0] {
        PH_TAG      = 5'b00001,
        PH_LEN_LO   = 5'b00010,
        PH_LEN_HI   = 5'b00100,
        PH_DATA     = 5'b01000,
        PH_FINISHED = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        ST_PARSING = 2'd0,
        ST_END     = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic       new_card;
        logic       read_timeout;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic                  id_char_valid;
        logic [7:0]            id_char;
        logic [ID_COUNT_W-1:0] id_index;
    } rsp_t;

    typedef struct packed {
        phase_t                  phase;
        logic [BYTES_LEFT_W-1:0] bytes_left;
        logic [7:0]              length_low;
        logic                    item_is_end;
        logic                    item_is_ansi;
        logic                    id_captured;
        logic                    id_stopped;
        logic [ID_COUNT_W-1:0]   id_count;
    } parse_state_t;

    localparam parse_state_t STATE_INIT = '{
        phase:        PH_TAG,
        bytes_left:   '0,
        length_low:   '0,
        item_is_end:  1'b0,
        item_is_ansi: 1'b0,
        id_captured:  1'b0,
        id_stopped:   1'b0,
        id_count:     '0
    };

endpackage

// File: design/prtp_req_if.sv
// Request channel of the tag parser: one resource-data byte with its flags.
// Depends on nothing.
interface prtp_req_if;
    logic       valid;
    logic       ready;
    logic       new_card;
    logic       read_timeout;
    logic [7:0] data_byte;

    modport source (output valid, output new_card, output read_timeout,
                    output data_byte, input ready);
    modport sink (input valid, input new_card, input read_timeout,
                  input data_byte, output ready);
endinterface

// File: design/prtp_rsp_if.sv
// Result channel of the tag parser: parse status and identifier character.
// Depends on nothing.
interface prtp_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       id_char_valid;
    logic [7:0] id_char;
    logic [6:0] id_index;

    modport source (output valid, output status, output id_char_valid,
                    output id_char, output id_index, input ready);
    modport sink (input valid, input status, input id_char_valid,
                  input id_char, input id_index, output ready);
endinterface

// File: design/prtp_in_stage.sv
// Input register of the tag parser: holds one accepted request.
// Depends on prtp_pkg and prtp_req_if.
module prtp_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    prtp_req_if.sink     req,
    input  logic         take,
    output logic         item_valid,
    output prtp_pkg::req_t item
);
    import prtp_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t item_reg;

    assign req.ready = !valid_reg || take;
    assign valid_next = req.ready ? req.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= '{new_card:     req.new_card,
                          read_timeout: req.read_timeout,
                          data_byte:    req.data_byte};
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;
endmodule

// File: design/prtp_step.sv
// Parser state and the combinational update that handles one byte.
// Depends on prtp_pkg.
module prtp_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  prtp_pkg::req_t item,
    output prtp_pkg::rsp_t result
);
    import prtp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t cur;
    parse_state_t upd;
    rsp_t res;
    logic [7:0] b;
    logic [BYTES_LEFT_W-1:0] len_large;
    logic [BYTES_LEFT_W-1:0] left_dec;

    assign b = item.data_byte;
    assign cur = item.new_card ? STATE_INIT : state_reg;
    assign len_large = {b, cur.length_low};
    assign left_dec = cur.bytes_left - BYTES_LEFT_W'(1);

    always_comb
    begin
        upd = cur;
        res = '{status: ST_PARSING, id_char_valid: 1'b0, id_char: '0, id_index: '0};
        if (cur.phase == PH_FINISHED)
        begin
            res.status = ST_IGNORED;
        end
        else if (item.read_timeout)
        begin
            res.status = ST_TIMEOUT;
            upd.phase = PH_FINISHED;
        end
        else
        begin
            case (cur.phase)
                PH_TAG:
                begin
                    if (!b[7])
                    begin
                        upd.item_is_end = (b[6:3] == TAG_END);
                        upd.item_is_ansi = 1'b0;
                        if (b[2:0] == 3'd0)
                        begin
                            if (b[6:3] == TAG_END)
                            begin
                                res.status = ST_END;
                                upd.phase = PH_FINISHED;
                            end
                        end
                        else
                        begin
                            upd.bytes_left = BYTES_LEFT_W'(b[2:0]);
                            upd.phase = PH_DATA;
                        end
                    end
                    else
                    begin
                        upd.item_is_end = 1'b0;
                        upd.item_is_ansi = (b[6:0] == TAG_ID_ANSI) && !cur.id_captured;
                        if ((b[6:0] == TAG_ID_ANSI) && !cur.id_captured)
                        begin
                            upd.id_stopped = 1'b0;
                            upd.id_count = '0;
                        end
                        upd.phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    upd.length_low = b;
                    upd.phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    upd.bytes_left = len_large;
                    upd.phase = (len_large == '0) ? PH_TAG : PH_DATA;
                end
                PH_DATA:
                begin
                    if (cur.item_is_ansi && !cur.id_stopped)
                    begin
                        if (b == 8'd0 || cur.id_count >= ID_LIMIT)
                        begin
                            upd.id_stopped = 1'b1;
                        end
                        else
                        begin
                            res.id_char_valid = 1'b1;
                            res.id_char = b;
                            res.id_index = cur.id_count;
                            upd.id_count = cur.id_count + ID_COUNT_W'(1);
                            upd.id_captured = 1'b1;
                        end
                    end
                    upd.bytes_left = left_dec;
                    if (left_dec == '0)
                    begin
                        if (cur.item_is_end)
                        begin
                            res.status = ST_END;
                            upd.phase = PH_FINISHED;
                        end
                        else
                        begin
                            upd.phase = PH_TAG;
                        end
                    end
                end
                default:
                begin
                    upd = cur;
                end
            endcase
        end
    end

    assign state_next = advance ? upd : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign result = res;
endmodule

// File: design/prtp_out_stage.sv
// Result register of the tag parser, driving the result channel.
// Depends on prtp_pkg and prtp_rsp_if.
module prtp_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  prtp_pkg::rsp_t result,
    output logic           space,
    prtp_rsp_if.source     rsp
);
    import prtp_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t result_reg;

    assign space = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.status = result_reg.status;
    assign rsp.id_char_valid = result_reg.id_char_valid;
    assign rsp.id_char = result_reg.id_char;
    assign rsp.id_index = result_reg.id_index;
endmodule

// File: design/pnp_resource_tag_parser.sv
// Top level of the plug-and-play resource-data tag parser.
// Depends on prtp_pkg, both channel interfaces and the three stage modules.
//
// The parser takes one resource-data byte per request and returns exactly one
// result per byte: the parse status and, for bytes of the first non-empty ANSI
// identifier string, the character and its position. It sustains one byte per
// clock cycle unless the result channel stalls; each result passes through
// the input register, the combinational state update and the result register.
// A request with new_card set restarts the parser for that byte. After the end
// item completes or a timeout is reported, every byte returns status ignored
// until the next new_card or reset.
module pnp_resource_tag_parser (
    input  logic       clk,
    input  logic       rst_n,
    prtp_req_if.sink   req,
    prtp_rsp_if.source rsp
);
    import prtp_pkg::*;

    logic item_valid;
    req_t item;
    rsp_t result;
    logic space;
    logic advance;

    assign advance = item_valid && space;

    prtp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    prtp_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    prtp_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .space  (space),
        .rsp    (rsp)
    );
endmodule

// File: design/prtp_checker.sv
// Port-level checks for the tag parser, bound to the top level.
// Depends on prtp_pkg and pnp_resource_tag_parser.
module prtp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       id_char_valid,
    input logic [7:0] id_char,
    input logic [6:0] id_index
);
    import prtp_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(id_char)
                                    && $stable(id_index))
        else $error("result payload changed while stalled");

    a_char_parsing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && id_char_valid |-> status == ST_PARSING && id_char != 8'd0)
        else $error("identifier character outside a parsing result");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !id_char_valid |-> id_char == 8'd0 && id_index == 7'd0)
        else $error("character fields not cleared without a character");
endmodule

bind pnp_resource_tag_parser prtp_checker u_prtp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .id_char_valid (rsp.id_char_valid),
    .id_char       (rsp.id_char),
    .id_index      (rsp.id_index)
);

// File: test/pnp_resource_tag_parser_test.sv
// Self-checking testbench for the resource-data tag parser top level.
// Depends on prtp_pkg, prtp_req_if, prtp_rsp_if and pnp_resource_tag_parser.
// Drives directed and random card byte streams and checks every result in order.
`timescale 1ns / 100ps

module pnp_resource_tag_parser_test;
    import prtp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_BYTES = 800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    prtp_req_if req_ch ();
    prtp_rsp_if rsp_ch ();

    pnp_resource_tag_parser i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    phase_t      card_phase;
    logic [15:0] skip_count;
    logic [7:0]  len_low_byte;
    logic        in_end_item;
    logic        in_ansi_item;
    logic        id_seen;
    logic        id_done;
    logic [6:0]  id_len;

    rsp_t parse_result_q[$];
    int   mismatch_count = 0;
    int   live_bytes = 0;
    int   cycle_count = 0;
    bit   steady_flow = 1'b0;
    bit   start_pending = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_card_state();
        card_phase   = PH_TAG;
        skip_count   = '0;
        len_low_byte = '0;
        in_end_item  = 1'b0;
        in_ansi_item = 1'b0;
        id_seen      = 1'b0;
        id_done      = 1'b0;
        id_len       = '0;
    endfunction

    function automatic rsp_t parse_byte(input req_t item);
        rsp_t       res;
        logic [7:0] b;
        res = '0;
        b = item.data_byte;
        if (item.new_card)
        begin
            clear_card_state();
        end
        if (card_phase == PH_FINISHED)
        begin
            res.status = ST_IGNORED;
        end
        else if (item.read_timeout)
        begin
            res.status = ST_TIMEOUT;
            card_phase = PH_FINISHED;
        end
        else
        begin
            case (card_phase)
                PH_TAG:
                begin
                    if (!b[7])
                    begin
                        in_end_item = (b[6:3] == TAG_END);
                        in_ansi_item = 1'b0;
                        if (b[2:0] == 3'd0)
                        begin
                            if (in_end_item)
                            begin
                                res.status = ST_END;
                                card_phase = PH_FINISHED;
                            end
                        end
                        else
                        begin
                            skip_count = {13'd0, b[2:0]};
                            card_phase = PH_DATA;
                        end
                    end
                    else
                    begin
                        in_end_item = 1'b0;
                        in_ansi_item = (b[6:0] == TAG_ID_ANSI) && !id_seen;
                        if (in_ansi_item)
                        begin
                            id_done = 1'b0;
                            id_len = '0;
                        end
                        card_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    len_low_byte = b;
                    card_phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    skip_count = {b, len_low_byte};
                    card_phase = (skip_count == 16'd0) ? PH_TAG : PH_DATA;
                end
                default:
                begin
                    if (in_ansi_item && !id_done)
                    begin
                        if (b == 8'h00 || id_len >= ID_LIMIT)
                        begin
                            id_done = 1'b1;
                        end
                        else
                        begin
                            res.id_char_valid = 1'b1;
                            res.id_char = b;
                            res.id_index = id_len;
                            id_len = id_len + 7'd1;
                            id_seen = 1'b1;
                        end
                    end
                    skip_count = skip_count - 16'd1;
                    if (skip_count == 16'd0)
                    begin
                        if (in_end_item)
                        begin
                            res.status = ST_END;
                            card_phase = PH_FINISHED;
                        end
                        else
                        begin
                            card_phase = PH_TAG;
                        end
                    end
                end
            endcase
        end
        return res;
    endfunction

    task automatic send_byte(input logic card_start, input logic poll_timeout,
                             input logic [7:0] value);
        req_t item;
        rsp_t want;
        int   gap;
        gap = steady_flow ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.new_card     <= card_start;
        req_ch.read_timeout <= poll_timeout;
        req_ch.data_byte    <= value;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        item = '{new_card: card_start, read_timeout: poll_timeout, data_byte: value};
        want = parse_byte(item);
        parse_result_q.push_back(want);
        if (want.status != ST_IGNORED)
        begin
            live_bytes++;
        end
    endtask

    task automatic send_plain(input logic [7:0] value);
        send_byte(start_pending, 1'b0, value);
        start_pending = 1'b0;
    endtask

    task automatic send_small_item(input logic [3:0] name, input logic [2:0] len);
        send_plain({1'b0, name, len});
        repeat (len) send_plain(8'($urandom_range(0, 255)));
    endtask

    task automatic send_large_item(input logic [6:0] name, input logic [15:0] len,
                                   input int nul_at);
        send_plain({1'b1, name});
        send_plain(len[7:0]);
        send_plain(len[15:8]);
        for (int i = 0; i < len; i++)
        begin
            if (i == nul_at)
                send_plain(8'h00);
            else if (name == TAG_ID_ANSI && (nul_at < 0 || i < nul_at))
                send_plain(8'($urandom_range(1, 255)));
            else
                send_plain(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (parse_result_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed_items();
        send_byte(1'b1, 1'b0, 8'h00);
        send_large_item(TAG_ID_ANSI, 16'd0, -1);
        send_large_item(TAG_ID_ANSI, 16'd1, 0);
        send_plain({1'b1, TAG_ID_ANSI});
        send_plain(8'h03);
        send_plain(8'h00);
        send_plain(8'h41);
        send_plain(8'hFF);
        send_plain(8'h01);
        send_large_item(TAG_ID_ANSI, 16'd1, -1);
        send_large_item({3'd0, TAG_END}, 16'd0, -1);
        send_plain(8'hFF);
        send_plain(8'h01);
        send_plain(8'h00);
        send_plain(8'h55);
        send_plain({1'b0, TAG_END, 3'd1});
        send_plain(8'hAA);
        send_byte(1'b0, 1'b0, 8'h12);
        send_byte(1'b0, 1'b1, 8'h34);
        send_byte(1'b1, 1'b0, {1'b0, TAG_END, 3'd0});
        send_byte(1'b1, 1'b1, 8'h00);
    endtask

    task automatic test_id_truncation();
        start_pending = 1'b1;
        send_large_item(TAG_ID_ANSI, 16'd130, -1);
        send_small_item(TAG_END, 3'd0);
    endtask

    task automatic test_long_item();
        steady_flow = 1'b1;
        start_pending = 1'b1;
        send_large_item(7'h11, 16'h0180, -1);
        send_small_item(TAG_END, 3'd2);
        steady_flow = 1'b0;
    endtask

    task automatic random_card();
        int          item_total;
        int          kind;
        int          nul_spot;
        logic [15:0] text_len;
        logic [3:0]  small_name;
        bit          finished;
        start_pending = 1'b1;
        finished = 1'b0;
        item_total = $urandom_range(0, 5);
        for (int k = 0; k < item_total && !finished; k++)
        begin
            kind = $urandom_range(0, 15);
            if (kind < 5)
            begin
                small_name = 4'($urandom_range(0, 15));
                send_small_item(small_name, 3'($urandom_range(0, 7)));
                finished = (small_name == TAG_END);
            end
            else if (kind < 9)
            begin
                send_large_item(7'($urandom_range(0, 127)), 16'($urandom_range(0, 8)), -1);
            end
            else if (kind < 14)
            begin
                text_len = 16'($urandom_range(0, 24));
                nul_spot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, text_len) : -1;
                send_large_item(TAG_ID_ANSI, text_len, nul_spot);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_byte(start_pending | ($urandom_range(0, 15) == 0),
                              $urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
                    start_pending = 1'b0;
                end
            end
        end
        if (!finished)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                send_small_item(TAG_END, 3'($urandom_range(0, 7)));
            end
            else
            begin
                send_byte(start_pending, 1'b1, 8'($urandom_range(0, 255)));
                start_pending = 1'b0;
            end
        end
        repeat ($urandom_range(0, 2))
            send_byte(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_cards();
        int target;
        int card_index;
        target = live_bytes + RANDOM_BYTES;
        card_index = 0;
        drain_requests();
        while (live_bytes < target)
        begin
            if (card_index % 10 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            if (card_index % 17 == 16)
                drain_requests();
            random_card();
            card_index++;
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (parse_result_q.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: status %0d valid %0d char %02h index %0d",
                             rsp_ch.status, rsp_ch.id_char_valid, rsp_ch.id_char,
                             rsp_ch.id_index);
                mismatch_count++;
            end
            else
            begin
                want = parse_result_q.pop_front();
                if (rsp_ch.status !== want.status ||
                    rsp_ch.id_char_valid !== want.id_char_valid ||
                    rsp_ch.id_char !== want.id_char ||
                    rsp_ch.id_index !== want.id_index)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display({"mismatch: expected status %0d valid %0d char %02h ",
                                  "index %0d, got status %0d valid %0d char %02h index %0d"},
                                 want.status, want.id_char_valid, want.id_char,
                                 want.id_index, rsp_ch.status, rsp_ch.id_char_valid,
                                 rsp_ch.id_char, rsp_ch.id_index);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        req_ch.valid        <= 1'b0;
        req_ch.new_card     <= 1'b0;
        req_ch.read_timeout <= 1'b0;
        req_ch.data_byte    <= 8'h00;
        clear_card_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_items();
        test_id_truncation();
        test_long_item();
        test_random_cards();
        drain_requests();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && parse_result_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
design/prtp_pkg.sv
design/prtp_req_if.sv
design/prtp_rsp_if.sv
design/prtp_in_stage.sv
design/prtp_step.sv
design/prtp_out_stage.sv
design/pnp_resource_tag_parser.sv
design/prtp_checker.sv
test/pnp_resource_tag_parser_test.sv
